### sv/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
// Used by lpht_ctrl, lpht_dpath and linear_probe_hash_table_top; depends on nothing.
`default_nettype none
package lpht_pkg;

  localparam logic [1:0]  OP_INSERT = 2'd0;
  localparam logic [1:0]  OP_FIND   = 2'd1;
  localparam logic [1:0]  OP_REMOVE = 2'd2;
  localparam logic [1:0]  OP_NOP    = 2'd3;

  localparam logic [63:0] HASH_SEED  = 64'd5381;
  localparam int          HASH_SHIFT = 5;
  localparam logic [6:0]  HASH_BITS  = 7'd64;

  localparam logic [10:0] SLOT_COUNT_RESET = 11'd1021;

  // one slot as stored in the table memory
  typedef struct packed {
    logic        used;
    logic [31:0] value;
    logic [63:0] key;
  } slot_t;

  // controller to datapath commands
  typedef struct packed {
    logic clr_wr;
    logic accept;
    logic hash_step;
    logic mod_start;
    logic mod_step;
    logic probe_start;
    logic rd_pos;
    logic rd_j;
    logic probe_next;
    logic wr_pos_used;
    logic wr_pos_free;
    logic wr_j_free;
    logic set_hit;
    logic set_full;
    logic cnt_inc;
    logic cnt_dec;
    logic j_start;
    logic j_next;
    logic reins_load;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       hash_done;
    logic       mod_done;
    logic       n_full;
    logic       rd_used;
    logic       rd_match;
    logic       jn_full;
    logic       out_busy;
    logic       clr_last;
    logic [1:0] op;
  } sts_t;

endpackage
`default_nettype wire

### sv/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 97,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/lpht_ctrl.sv
// Sequencer for the hash table: clear pass, hash, modulo, probe, remove cluster repair.
// Depends on lpht_pkg.
`default_nettype none
module lpht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_CHK   = 4'd5;
  localparam logic [3:0] S_JRD   = 4'd6;
  localparam logic [3:0] S_JCHK  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state, state_next;
  logic       reins, reins_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      reins <= 1'b0;
    end else begin
      state <= state_next;
      reins <= reins_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    reins_next = reins;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          reins_next = 1'b0;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (sts.op == lpht_pkg::OP_NOP && !reins) begin
          state_next = S_DONE;
        end else if (sts.hash_done) begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.probe_start = 1'b1;
          state_next      = S_RD;
        end else begin
          cmd.mod_step = 1'b1;
        end
      end
      S_RD: begin
        if (sts.n_full) begin
          // every active slot visited
          if (!reins && sts.op == lpht_pkg::OP_INSERT) cmd.set_full = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.rd_pos = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (reins) begin
          if (!sts.rd_used || sts.rd_match) begin
            cmd.wr_pos_used = 1'b1;
            cmd.j_next      = 1'b1;
            state_next      = S_JRD;
          end else begin
            cmd.probe_next = 1'b1;
            state_next     = S_RD;
          end
        end else if (sts.rd_used && sts.rd_match) begin
          cmd.set_hit = 1'b1;
          state_next  = S_DONE;
          if (sts.op == lpht_pkg::OP_INSERT) begin
            cmd.wr_pos_used = 1'b1;
          end else if (sts.op == lpht_pkg::OP_REMOVE) begin
            cmd.wr_pos_free = 1'b1;
            cmd.cnt_dec     = 1'b1;
            cmd.j_start     = 1'b1;
            state_next      = S_JRD;
          end
        end else if (!sts.rd_used) begin
          if (sts.op == lpht_pkg::OP_INSERT) begin
            cmd.wr_pos_used = 1'b1;
            cmd.cnt_inc     = 1'b1;
          end
          state_next = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_RD;
        end
      end
      S_JRD: begin
        if (sts.jn_full) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_j   = 1'b1;
          state_next = S_JCHK;
        end
      end
      S_JCHK: begin
        if (!sts.rd_used) begin
          state_next = S_DONE;
        end else begin
          cmd.wr_j_free  = 1'b1;
          cmd.reins_load = 1'b1;
          reins_next     = 1'b1;
          state_next     = S_HASH;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### sv/lpht_dpath.sv
// Datapath of the hash table: key canonical form, djb2 hash, bit-serial modulo,
// probe pointers, memory access, entry count and result register. Depends on lpht_pkg.
`default_nettype none
module lpht_dpath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 8,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = AW + 1
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire lpht_pkg::cmd_t         cmd,
  output lpht_pkg::sts_t              sts,
  input  wire logic [CW-1:0]          cap,
  input  wire logic [1:0]             in_operation,
  input  wire logic [63:0]            in_key_bytes,
  input  wire logic [31:0]            in_value,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output lpht_pkg::slot_t             ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  wire lpht_pkg::slot_t        ram_rdata,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        hit,
  output logic [31:0]                 value_out,
  output logic                        status,
  output logic [10:0]                 entry_count
);

  logic [1:0]    op;
  logic [63:0]   key;
  logic [31:0]   val;
  logic [63:0]   h;
  logic [3:0]    hb;
  logic [CW-1:0] rem;
  logic [6:0]    mc;
  logic [AW-1:0] pos;
  logic [CW-1:0] n;
  logic [AW-1:0] j;
  logic [CW-1:0] jn;
  logic          r_hit;
  logic [31:0]   r_vout;
  logic          r_full;
  logic [10:0]   count;

  logic [63:0]   canon;
  logic          alive;
  logic [7:0]    cur_byte;
  logic [CW:0]   trial;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x, input logic [CW-1:0] c);
    logic [CW-1:0] nx;
    nx = {1'b0, x} + CW'(1);
    return (nx == c) ? '0 : nx[AW-1:0];
  endfunction

  // keep bytes before the first zero byte, at most KEY_BYTES of them
  always_comb begin
    canon = '0;
    alive = 1'b1;
    for (int b = 0; b < 8; b++) begin
      alive = alive && (b < KEY_BYTES) && (in_key_bytes[8*b +: 8] != 8'd0);
      if (alive) canon[8*b +: 8] = in_key_bytes[8*b +: 8];
    end
  end

  assign cur_byte = key[{hb[2:0], 3'b000} +: 8];
  assign trial    = {rem, h[63]};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op  <= in_operation;
      key <= canon;
      val <= in_value;
      h   <= lpht_pkg::HASH_SEED;
      hb  <= '0;
    end else if (cmd.reins_load) begin
      key <= ram_rdata.key;
      val <= ram_rdata.value;
      h   <= lpht_pkg::HASH_SEED;
      hb  <= '0;
    end else if (cmd.hash_step) begin
      h  <= (h << lpht_pkg::HASH_SHIFT) + h + {56'd0, cur_byte};
      hb <= hb + 4'd1;
    end else if (cmd.mod_step) begin
      h <= h << 1;
    end
    if (cmd.mod_start) begin
      rem <= '0;
      mc  <= '0;
    end else if (cmd.mod_step) begin
      rem <= (trial >= {1'b0, cap}) ? CW'(trial - {1'b0, cap}) : trial[CW-1:0];
      mc  <= mc + 7'd1;
    end
    if (cmd.probe_start) begin
      n <= '0;
    end else if (cmd.probe_next) begin
      n <= n + CW'(1);
    end
    if (cmd.j_start) begin
      j  <= wrap_inc(pos, cap);
      jn <= '0;
    end else if (cmd.j_next) begin
      j  <= wrap_inc(j, cap);
      jn <= jn + CW'(1);
    end
    if (cmd.accept) begin
      r_hit  <= 1'b0;
      r_vout <= '0;
      r_full <= 1'b0;
    end else begin
      if (cmd.set_hit) begin
        r_hit  <= 1'b1;
        r_vout <= ram_rdata.value;
      end
      if (cmd.set_full) r_full <= 1'b1;
    end
    if (cmd.out_load) begin
      hit         <= r_hit;
      value_out   <= r_vout;
      status      <= r_full;
      entry_count <= count;
    end
  end

  // pos doubles as the clear-pass address after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        pos <= pos + AW'(1);
      end else if (cmd.probe_start) begin
        pos <= rem[AW-1:0];
      end else if (cmd.probe_next) begin
        pos <= wrap_inc(pos, cap);
      end
      if (cmd.cnt_inc) begin
        count <= count + 11'd1;
      end else if (cmd.cnt_dec) begin
        count <= count - 11'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    ram_we          = cmd.clr_wr | cmd.wr_pos_used | cmd.wr_pos_free | cmd.wr_j_free;
    ram_waddr       = cmd.wr_j_free ? j : pos;
    ram_wdata.used  = cmd.wr_pos_used;
    ram_wdata.value = val;
    ram_wdata.key   = key;
    ram_raddr       = cmd.rd_j ? j : pos;
  end

  always_comb begin
    sts.hash_done = (hb == 4'(KEY_BYTES)) || (cur_byte == 8'd0);
    sts.mod_done  = (mc == lpht_pkg::HASH_BITS);
    sts.n_full    = (n == cap);
    sts.rd_used   = ram_rdata.used;
    sts.rd_match  = (ram_rdata.key == key);
    sts.jn_full   = (jn == cap);
    sts.out_busy  = out_valid & ~out_ready;
    sts.clr_last  = (pos == AW'(TABLE_DEPTH - 1));
    sts.op        = op;
  end

endmodule
`default_nettype wire

### sv/linear_probe_hash_table_top.sv
// Top level of the open-addressing hash table with linear probing and djb2 keys.
// Depends on lpht_pkg, lpht_ram, lpht_ctrl and lpht_dpath.
//
//   port group   dir  fields (low bit first)
//   s_t*         in   operation[1:0], key_bytes[65:2], value_in[97:66], zero pad to 104
//   m_t*         out  hit[0], value_out[32:1], status[33], entry_count[44:34], pad to 48
//   APB p*       cfg  slot_count at byte address 0, 11 bits
//
// One word at a time. Per word: an accept step, a djb2 hash over at most KEY_BYTES
// key bytes (it stops at the first zero byte), a bit-serial modulo over all 64 hash
// bits, one memory read per probed slot until a match, a free slot or every slot
// was visited, and a finish step. An unused operation code skips hash, modulo and probe.
// A remove adds, for each following entry of the cluster, a free-slot write plus a
// full rehash, modulo and probe to re-insert it, and one more read for the free slot
// that ends the cluster; the single read port of the table memory sets this cost.
// After reset a clearing pass over all TABLE_DEPTH slots marks every slot free;
// s_tready stays low until it ends. A result waits in the output register under
// m_tready low; the next word is taken while it waits, and its own result is held
// in the finish state until the register frees up.
`default_nettype none
module linear_probe_hash_table_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_BYTES   = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [103:0] s_tdata,  // operation, key_bytes, value_in
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [47:0]       m_tdata,  // hit, value_out, status, entry_count
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = $bits(lpht_pkg::slot_t);

  logic [10:0]     slot_count;
  logic [31:0]     cap_full;
  logic [CW-1:0]   cap;
  lpht_pkg::cmd_t  cmd;
  lpht_pkg::sts_t  sts;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [AW-1:0]   ram_raddr;
  lpht_pkg::slot_t ram_wdata;
  lpht_pkg::slot_t ram_rdata;
  logic [SW-1:0]   ram_rbits;
  logic            hit;
  logic [31:0]     value_out;
  logic            status;
  logic [10:0]     entry_count;

  // slot_count register; only register index 0 exists
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= lpht_pkg::SLOT_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      slot_count <= pwdata[10:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, slot_count} : 32'd0;

  // saturate the modulus into [2, TABLE_DEPTH]
  always_comb begin
    cap_full = {21'd0, slot_count};
    if (cap_full < 32'd2) cap_full = 32'd2;
    if (cap_full > 32'(TABLE_DEPTH)) cap_full = 32'(TABLE_DEPTH);
  end
  assign cap = cap_full[CW-1:0];

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpht_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cap          (cap),
    .in_operation (s_tdata[1:0]),
    .in_key_bytes (s_tdata[65:2]),
    .in_value     (s_tdata[97:66]),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .hit          (hit),
    .value_out    (value_out),
    .status       (status),
    .entry_count  (entry_count)
  );

  lpht_ram #(
    .WIDTH (SW),
    .DEPTH (TABLE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );
  assign ram_rdata = lpht_pkg::slot_t'(ram_rbits);

  // pack the result word, first field in the low bits
  assign m_tdata = {3'd0, entry_count, status, value_out, hit};

endmodule
`default_nettype wire
